// ===== rtl/mbec_pkg.sv =====
// ----------------------------------------------------------------------------
// mbec_pkg - shared types and constants for the Mandelbrot escape block
// Fixed-point formats, result codes, register indexes, sequencer states
// and the 40-bit saturation helper.
// ----------------------------------------------------------------------------
package mbec_pkg;

	// Q11.28 internal format, Q3.28 input format
	localparam int unsigned QFRAC = 28;
	localparam int unsigned ZW    = 40;
	localparam int unsigned CW    = 32;

	// escape bound 4.0 in Q.28, widened for the sum of two squares
	localparam logic signed [40:0] ESCAPE_LIMIT = 41'sd1073741824;

	// saturation bounds of the 40-bit internal format
	localparam logic signed [41:0] SAT_HI = 42'sd549755813887;
	localparam logic signed [41:0] SAT_LO = -42'sd549755813888;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_ITERATIONS  = 2'd0;
	localparam logic [1:0] CFG_CYCLE_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_SHADOW_PERIOD   = 2'd2;

	// register reset values
	localparam logic [15:0] MAX_ITERATIONS_RST  = 16'd1000;
	localparam logic [30:0] CYCLE_THRESHOLD_RST = 31'd26843546;
	localparam logic [7:0]  SHADOW_PERIOD_RST   = 8'd16;

	typedef enum logic [1:0] {
		OUTCOME_ESCAPED = 2'd0,
		OUTCOME_LIMIT   = 2'd1,
		OUTCOME_CYCLE   = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [15:0] max_iterations;
		logic [30:0] cycle_threshold;
		logic [7:0]  shadow_period;
	} cfg_t;

	// status from the sequencer to the port logic
	typedef struct packed {
		logic     idle;
		logic     res_valid;
		outcome_t outcome;
	} core_stat_t;

	typedef enum logic [2:0] {
		QM_IDLE,
		QM_MUL,
		QM_DRAIN,
		QM_FIN,
		QM_DONE
	} qm_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_STEP,
		C_SH_RR,
		C_SH_II,
		C_SH_RI,
		C_SH_UPD,
		C_OR_RR,
		C_OR_II,
		C_OR_RI,
		C_OR_UPD,
		C_DIFF,
		C_ABS,
		C_DECIDE,
		C_DONE
	} core_state_t;

	// clamp a 42-bit signed value into the 40-bit internal range
	function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
		logic signed [39:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[39:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[39:0];
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/mbec_if.sv =====
// ----------------------------------------------------------------------------
// mbec_if - valid/ready channels of the Mandelbrot escape block
// Point channel (c_real, c_imag) and verdict channel (outcome).
// ----------------------------------------------------------------------------
interface mbec_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] c_real;
	logic signed [31:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbec_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;

	modport source (output valid, output outcome, input ready);
	modport sink   (input valid, input outcome, output ready);
endinterface

// ===== rtl/mbec_qmul.sv =====
// ----------------------------------------------------------------------------
// mbec_qmul - shared Q11.28 multiplier
// Forms |a|*|b| from four 20x20 partial products on one multiplier, keeps
// the top partial apart, truncates toward zero, applies the sign and
// saturates to 40 bits. Done is raised in DONE, after the MUL, DRAIN and FIN states.
// ----------------------------------------------------------------------------
module mbec_qmul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [39:0] a,
	input  logic signed [39:0] b,
	output logic               done,
	output logic signed [39:0] res
);

	mbec_pkg::qm_state_t state_q, state_d;

	logic        mul_en;
	logic        fin_en;
	logic [39:0] ua_q, ub_q;
	logic        neg_q;
	logic [1:0]  cnt_q;
	logic [19:0] mx, my;
	logic [39:0] prod;
	logic [39:0] p_s1;
	logic [1:0]  kind_s1;
	logic        pv_s1;
	logic [39:0] hi_q;
	logic [60:0] acc_q;
	logic [40:0] mag;
	logic [40:0] mag_c;
	logic signed [39:0] fin_val;
	logic signed [39:0] res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbec_pkg::QM_IDLE:  if (start) state_d = mbec_pkg::QM_MUL;
			mbec_pkg::QM_MUL:   if (cnt_q == 2'd3) state_d = mbec_pkg::QM_DRAIN;
			mbec_pkg::QM_DRAIN: state_d = mbec_pkg::QM_FIN;
			mbec_pkg::QM_FIN:   state_d = mbec_pkg::QM_DONE;
			mbec_pkg::QM_DONE:  state_d = mbec_pkg::QM_IDLE;
			default:            state_d = mbec_pkg::QM_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		mul_en = 1'b0;
		fin_en = 1'b0;
		done   = 1'b0;
		unique case (state_q)
			mbec_pkg::QM_MUL:  mul_en = 1'b1;
			mbec_pkg::QM_FIN:  fin_en = 1'b1;
			mbec_pkg::QM_DONE: done   = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbec_pkg::QM_IDLE;
			pv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= mul_en;
		end
	end

	// pick the partial: high*high, high*low, low*high, low*low
	assign mx   = cnt_q[1] ? ua_q[19:0] : ua_q[39:20];
	assign my   = cnt_q[0] ? ub_q[19:0] : ub_q[39:20];
	assign prod = mx * my;

	// latch magnitudes, run the multiplier, accumulate each product in the cycle after it is formed
	always_ff @(posedge clk) begin
		if (start && (state_q == mbec_pkg::QM_IDLE)) begin
			ua_q  <= a[39] ? 40'(-a) : 40'(a);
			ub_q  <= b[39] ? 40'(-b) : 40'(b);
			neg_q <= a[39] ^ b[39];
			cnt_q <= 2'd0;
			hi_q  <= '0;
			acc_q <= '0;
		end else begin
			if (mul_en) begin
				p_s1    <= prod;
				kind_s1 <= cnt_q;
				cnt_q   <= cnt_q + 2'd1;
			end
			if (pv_s1) begin
				priority if (kind_s1 == 2'd0) begin
					hi_q <= p_s1;
				end else if (kind_s1 == 2'd3) begin
					acc_q <= acc_q + 61'(p_s1);
				end else begin
					acc_q <= acc_q + {1'b0, p_s1, 20'd0};
				end
			end
		end
		if (fin_en) begin
			res_q <= fin_val;
		end
	end

	// truncate toward zero, saturate the magnitude, then apply the sign
	assign mag = {2'b00, hi_q[26:0], 12'd0} + 41'(acc_q[60:28]);
	always_comb begin
		mag_c = (|hi_q[39:27]) ? 41'h080_0000_0000 : mag;
		if (neg_q) begin
			if (mag_c > 41'h080_0000_0000) begin
				fin_val = 40'h80_0000_0000;
			end else begin
				fin_val = 40'(-mag_c);
			end
		end else if (mag_c > 41'h07F_FFFF_FFFF) begin
			fin_val = 40'h7F_FFFF_FFFF;
		end else begin
			fin_val = mag_c[39:0];
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/mbec_core.sv =====
// ----------------------------------------------------------------------------
// mbec_core - step sequencer of the escape test
// Walks one point through shadow advance, orbit squaring, update and the
// distance, limit and escape checks, issuing every product to the shared
// multiplier and holding the verdict until the port logic takes it.
// ----------------------------------------------------------------------------
module mbec_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [31:0]   c_real,
	input  logic signed [31:0]   c_imag,
	input  mbec_pkg::cfg_t       cfg,
	input  logic                 res_ready,
	output mbec_pkg::core_stat_t stat
);

	mbec_pkg::core_state_t state_q, state_d;

	logic signed [31:0] cr_q, ci_q;
	logic signed [39:0] zr_q, zi_q, sr_q, si_q;
	logic signed [39:0] rr_q, ii_q, ri_q;
	logic [15:0]        step_q;
	logic [7:0]         per_q;
	logic               esc_q;
	logic signed [40:0] dr_q, di_q;
	logic [40:0]        mr_q, mi_q;
	mbec_pkg::outcome_t outcome_q;

	logic               is_mul;
	logic               pend_q;
	logic               qm_start;
	logic               qm_done;
	logic signed [39:0] qm_a, qm_b, qm_res;

	logic signed [39:0] twice_ri;
	logic signed [39:0] new_im, new_re;
	logic [41:0]        l1_dist;
	logic               hit_cycle, hit_limit, finish;

	mbec_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (qm_start),
		.a      (qm_a),
		.b      (qm_b),
		.done   (qm_done),
		.res    (qm_res)
	);

	// verdict of the step just finished
	assign l1_dist   = 42'(mr_q) + 42'(mi_q);
	assign hit_cycle = l1_dist < {11'd0, cfg.cycle_threshold};
	assign hit_limit = step_q == cfg.max_iterations;
	assign finish    = hit_cycle || hit_limit || esc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbec_pkg::C_IDLE:   if (start) state_d = mbec_pkg::C_STEP;
			mbec_pkg::C_STEP: begin
				if (per_q == cfg.shadow_period) begin
					state_d = mbec_pkg::C_SH_RR;
				end else begin
					state_d = mbec_pkg::C_OR_RR;
				end
			end
			mbec_pkg::C_SH_RR:  if (qm_done) state_d = mbec_pkg::C_SH_II;
			mbec_pkg::C_SH_II:  if (qm_done) state_d = mbec_pkg::C_SH_RI;
			mbec_pkg::C_SH_RI:  if (qm_done) state_d = mbec_pkg::C_SH_UPD;
			mbec_pkg::C_SH_UPD: state_d = mbec_pkg::C_OR_RR;
			mbec_pkg::C_OR_RR:  if (qm_done) state_d = mbec_pkg::C_OR_II;
			mbec_pkg::C_OR_II:  if (qm_done) state_d = mbec_pkg::C_OR_RI;
			mbec_pkg::C_OR_RI:  if (qm_done) state_d = mbec_pkg::C_OR_UPD;
			mbec_pkg::C_OR_UPD: state_d = mbec_pkg::C_DIFF;
			mbec_pkg::C_DIFF:   state_d = mbec_pkg::C_ABS;
			mbec_pkg::C_ABS:    state_d = mbec_pkg::C_DECIDE;
			mbec_pkg::C_DECIDE: state_d = finish ? mbec_pkg::C_DONE : mbec_pkg::C_STEP;
			mbec_pkg::C_DONE:   if (res_ready) state_d = mbec_pkg::C_IDLE;
			default:            state_d = mbec_pkg::C_IDLE;
		endcase
	end

	// operand select for the shared multiplier and status outputs
	always_comb begin
		is_mul = 1'b1;
		qm_a   = '0;
		qm_b   = '0;
		unique case (state_q)
			mbec_pkg::C_SH_RR: begin
				qm_a = sr_q;
				qm_b = sr_q;
			end
			mbec_pkg::C_SH_II: begin
				qm_a = si_q;
				qm_b = si_q;
			end
			mbec_pkg::C_SH_RI: begin
				qm_a = sr_q;
				qm_b = si_q;
			end
			mbec_pkg::C_OR_RR: begin
				qm_a = zr_q;
				qm_b = zr_q;
			end
			mbec_pkg::C_OR_II: begin
				qm_a = zi_q;
				qm_b = zi_q;
			end
			mbec_pkg::C_OR_RI: begin
				qm_a = zr_q;
				qm_b = zi_q;
			end
			default: is_mul = 1'b0;
		endcase
		qm_start       = is_mul && !pend_q;
		stat.idle      = state_q == mbec_pkg::C_IDLE;
		stat.res_valid = state_q == mbec_pkg::C_DONE;
		stat.outcome   = outcome_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbec_pkg::C_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (qm_done) begin
				pend_q <= 1'b0;
			end else if (qm_start) begin
				pend_q <= 1'b1;
			end
		end
	end

	// z*z + c from the three products, shared by orbit and shadow
	assign twice_ri = mbec_pkg::sat40({ri_q[39], ri_q, 1'b0});
	assign new_im   = mbec_pkg::sat40(42'({{2{twice_ri[39]}}, twice_ri})
		+ 42'({{10{ci_q[31]}}, ci_q}));
	assign new_re   = mbec_pkg::sat40(42'({{2{rr_q[39]}}, rr_q})
		- 42'({{2{ii_q[39]}}, ii_q}) + 42'({{10{cr_q[31]}}, cr_q}));

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mbec_pkg::C_IDLE: begin
				if (start) begin
					cr_q   <= c_real;
					ci_q   <= c_imag;
					zr_q   <= '0;
					zi_q   <= '0;
					sr_q   <= '0;
					si_q   <= '0;
					step_q <= '0;
					per_q  <= '0;
				end
			end
			mbec_pkg::C_SH_RR, mbec_pkg::C_OR_RR: if (qm_done) rr_q <= qm_res;
			mbec_pkg::C_SH_II, mbec_pkg::C_OR_II: if (qm_done) ii_q <= qm_res;
			mbec_pkg::C_SH_RI, mbec_pkg::C_OR_RI: if (qm_done) ri_q <= qm_res;
			mbec_pkg::C_SH_UPD: begin
				sr_q  <= new_re;
				si_q  <= new_im;
				per_q <= '0;
			end
			mbec_pkg::C_OR_UPD: begin
				zr_q   <= new_re;
				zi_q   <= new_im;
				step_q <= step_q + 16'd1;
				per_q  <= per_q + 8'd1;
				// escape uses the squares taken before this update
				esc_q  <= (41'({rr_q[39], rr_q}) + 41'({ii_q[39], ii_q}))
					>= mbec_pkg::ESCAPE_LIMIT;
			end
			mbec_pkg::C_DIFF: begin
				dr_q <= 41'({zr_q[39], zr_q}) - 41'({sr_q[39], sr_q});
				di_q <= 41'({zi_q[39], zi_q}) - 41'({si_q[39], si_q});
			end
			mbec_pkg::C_ABS: begin
				mr_q <= dr_q[40] ? 41'(-dr_q) : 41'(dr_q);
				mi_q <= di_q[40] ? 41'(-di_q) : 41'(di_q);
			end
			mbec_pkg::C_DECIDE: begin
				// cycle beats limit, limit beats escape
				priority if (hit_cycle) begin
					outcome_q <= mbec_pkg::OUTCOME_CYCLE;
				end else if (hit_limit) begin
					outcome_q <= mbec_pkg::OUTCOME_LIMIT;
				end else begin
					outcome_q <= mbec_pkg::OUTCOME_ESCAPED;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/mandelbrot_escape_with_cycle_check.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_with_cycle_check - Mandelbrot escape test, top level
// Steps: each iteration runs STEP, OR_RR, OR_II, OR_RI, OR_UPD, DIFF, ABS,
//   DECIDE, with SH_RR, SH_II, SH_RI, SH_UPD before OR_RR on a shadow step.
// Throughput: one point at a time, the next point taken once the sequencer
//   is idle again; each product holds the shared 20x20 multiplier.
// Reset: registers return to 1000 / 0.1 / 16, the block is idle and empty.
// ----------------------------------------------------------------------------
module mandelbrot_escape_with_cycle_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	mbec_point_if.sink      point,
	mbec_verdict_if.source  verdict
);

	mbec_pkg::cfg_t       cfg_q;
	mbec_pkg::core_stat_t stat;
	mbec_pkg::outcome_t   out_q;
	logic                 out_valid_q;
	logic                 res_ready;
	logic                 take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations  <= mbec_pkg::MAX_ITERATIONS_RST;
			cfg_q.cycle_threshold <= mbec_pkg::CYCLE_THRESHOLD_RST;
			cfg_q.shadow_period   <= mbec_pkg::SHADOW_PERIOD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mbec_pkg::CFG_MAX_ITERATIONS:  cfg_q.max_iterations  <= cfg_data[15:0];
				mbec_pkg::CFG_CYCLE_THRESHOLD: cfg_q.cycle_threshold <= cfg_data;
				mbec_pkg::CFG_SHADOW_PERIOD:   cfg_q.shadow_period   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// accept a point whenever the sequencer is free
	assign point.ready = stat.idle;
	assign take        = point.valid && stat.idle;

	mbec_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (take),
		.c_real    (point.c_real),
		.c_imag    (point.c_imag),
		.cfg       (cfg_q),
		.res_ready (res_ready),
		.stat      (stat)
	);

	// output word register: hold until the sink takes it
	assign res_ready = !out_valid_q || verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && stat.res_valid) begin
			out_q <= stat.outcome;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.outcome = out_q;

endmodule
